// ===== hw/rtl/cbba_pkg.sv =====
// shared constants, codes and types of the circular bitmap block allocator
package cbba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_NUM_BLOCKS = 1'b0;

    localparam logic [CNT_W-1:0] NUM_BLOCKS_RST = CNT_W'(MAX_BLOCKS);

    // result status codes
    localparam logic [1:0] STAT_CLAIMED = 2'd0;
    localparam logic [1:0] STAT_USED    = 2'd1;
    localparam logic [1:0] STAT_NOSPACE = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [BLK_W-1:0] block_index;
        logic [1:0]       status;
        logic             last;
    } result_t;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FAIL  = 4'b1000
    } seq_state_t;

endpackage

// ===== hw/rtl/cbba_ram.sv =====
// generic single-write, single-read ram with registered read data
module cbba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/cbba_seq.sv =====
// allocation sequencer: clearing pass, start check and circular scan over the bitmap ram
module cbba_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [cbba_pkg::CNT_W-1:0] nb_eff,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [cbba_pkg::BLK_W-1:0] s_first_block,
    input  logic [cbba_pkg::CNT_W-1:0] s_file_length,
    input  logic                       out_free,
    output cbba_pkg::result_t          res
);

    cbba_pkg::seq_state_t state_reg, state_next;

    logic [cbba_pkg::BLK_W-1:0] clr_reg, clr_next;
    logic [cbba_pkg::BLK_W-1:0] rd_pos_reg, rd_pos_next;
    logic [cbba_pkg::CNT_W-1:0] len_reg, len_next;
    logic [cbba_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [cbba_pkg::CNT_W-1:0] vis_reg, vis_next;
    logic                       first_reg, first_next;

    logic                       we;
    logic [cbba_pkg::BLK_W-1:0] waddr;
    logic                       wdata;
    logic                       re;
    logic [cbba_pkg::BLK_W-1:0] raddr;
    logic                       rdata;

    logic [cbba_pkg::CNT_W-1:0] pos_inc;
    logic [cbba_pkg::BLK_W-1:0] pos_wrap;
    logic [cbba_pkg::CNT_W-1:0] cnt_new;
    logic [cbba_pkg::CNT_W-1:0] vis_new;
    logic                       reject;
    logic                       claim;

    cbba_ram #(
        .WIDTH (1),
        .DEPTH (cbba_pkg::MAX_BLOCKS)
    ) u_map (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_ready = (state_reg == cbba_pkg::S_IDLE);

    always_comb begin
        pos_inc  = {1'b0, rd_pos_reg} + cbba_pkg::CNT_W'(1);
        pos_wrap = (pos_inc >= nb_eff) ? '0 : pos_inc[cbba_pkg::BLK_W-1:0];
        reject   = first_reg && (({1'b0, rd_pos_reg} >= nb_eff) || rdata);
        claim    = !rdata;
        cnt_new  = cnt_reg + cbba_pkg::CNT_W'(claim);
        vis_new  = vis_reg + cbba_pkg::CNT_W'(1);
    end

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        rd_pos_next = rd_pos_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        vis_next    = vis_reg;
        first_next  = first_reg;
        we          = 1'b0;
        waddr       = rd_pos_reg;
        wdata       = 1'b1;
        re          = 1'b0;
        raddr       = pos_wrap;
        res         = '0;
        case (state_reg)
            cbba_pkg::S_CLEAR: begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = 1'b0;
                clr_next = clr_reg + cbba_pkg::BLK_W'(1);
                if (clr_reg == cbba_pkg::BLK_W'(cbba_pkg::MAX_BLOCKS - 1)) begin
                    state_next = cbba_pkg::S_IDLE;
                end
            end
            cbba_pkg::S_IDLE: begin
                if (s_valid) begin
                    re          = 1'b1;
                    raddr       = s_first_block;
                    rd_pos_next = s_first_block;
                    first_next  = 1'b1;
                    cnt_next    = '0;
                    vis_next    = '0;
                    if (s_file_length == '0) begin
                        len_next = cbba_pkg::CNT_W'(1);
                    end else if (s_file_length > cbba_pkg::CNT_W'(cbba_pkg::MAX_BLOCKS)) begin
                        len_next = cbba_pkg::CNT_W'(cbba_pkg::MAX_BLOCKS);
                    end else begin
                        len_next = s_file_length;
                    end
                    state_next = cbba_pkg::S_SCAN;
                end
            end
            cbba_pkg::S_SCAN: begin
                if (reject) begin
                    if (out_free) begin
                        res        = '{1'b1, '0, cbba_pkg::STAT_USED, 1'b1};
                        state_next = cbba_pkg::S_IDLE;
                    end
                end else if (!claim || out_free) begin
                    // a used block is skipped even while the output stalls
                    if (claim) begin
                        we  = 1'b1;
                        res = '{1'b1, rd_pos_reg, cbba_pkg::STAT_CLAIMED, cnt_new == len_reg};
                    end
                    cnt_next   = cnt_new;
                    vis_next   = vis_new;
                    first_next = 1'b0;
                    if (cnt_new < len_reg && vis_new < nb_eff) begin
                        re          = 1'b1;
                        rd_pos_next = pos_wrap;
                    end else if (cnt_new < len_reg) begin
                        state_next = cbba_pkg::S_FAIL;
                    end else begin
                        state_next = cbba_pkg::S_IDLE;
                    end
                end
            end
            cbba_pkg::S_FAIL: begin
                if (out_free) begin
                    res        = '{1'b1, '0, cbba_pkg::STAT_NOSPACE, 1'b1};
                    state_next = cbba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cbba_pkg::S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbba_pkg::S_CLEAR;
            clr_reg   <= '0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_pos_reg <= rd_pos_next;
        len_reg    <= len_next;
        cnt_reg    <= cnt_next;
        vis_reg    <= vis_next;
    end

endmodule

// ===== hw/rtl/circular_bitmap_block_allocator.sv =====
// top level: apb register, allocation sequencer and result output register
//
// Takes allocation requests (first_block, file_length) on the s_ valid/ready
// channel and returns one beat per claimed block on the m_ channel, in chain
// order, with last on the final beat. A used or out-of-range start block gives
// a single status 1 beat; a full circle without enough free blocks gives the
// claimed beats and then a status 2 beat. num_blocks (APB, address 0) sets
// where the scan wraps; write it only while the block is idle.
// One request at a time: s_ready is high only between requests. The single
// read port of the bitmap ram is read once per visited block. The start block
// is read in the accepting cycle and each beat passes through the output
// register. Results sit in one output register; while it is held by a low
// m_ready the scan pauses at the next free block and skips used ones.
// After reset the bitmap ram is cleared one entry a cycle, all 64 entries,
// with s_ready low; num_blocks returns to 64 at once.
module circular_bitmap_block_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cbba_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cbba_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cbba_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [5:0]                      s_first_block,
    input  logic [6:0]                      s_file_length,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [5:0]                      m_block_index,
    output logic [1:0]                      m_status,
    output logic                            m_last
);

    logic [cbba_pkg::CNT_W-1:0] num_blocks_reg;
    logic [cbba_pkg::CNT_W-1:0] nb_eff;
    logic                       reg_sel;

    logic                       m_valid_reg;
    logic [cbba_pkg::BLK_W-1:0] block_index_reg;
    logic [1:0]                 status_reg;
    logic                       last_reg;

    logic                       out_free;
    cbba_pkg::result_t          res;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == cbba_pkg::REG_NUM_BLOCKS);
    assign prdata  = reg_sel ? cbba_pkg::CFG_DATA_W'(num_blocks_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_blocks_reg <= cbba_pkg::NUM_BLOCKS_RST;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            num_blocks_reg <= pwdata[cbba_pkg::CNT_W-1:0];
        end
    end

    // zero acts as one, anything above the bitmap size as the full size
    always_comb begin
        if (num_blocks_reg == '0) begin
            nb_eff = cbba_pkg::CNT_W'(1);
        end else if (num_blocks_reg > cbba_pkg::CNT_W'(cbba_pkg::MAX_BLOCKS)) begin
            nb_eff = cbba_pkg::CNT_W'(cbba_pkg::MAX_BLOCKS);
        end else begin
            nb_eff = num_blocks_reg;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    cbba_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .nb_eff        (nb_eff),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_first_block (s_first_block),
        .s_file_length (s_file_length),
        .out_free      (out_free),
        .res           (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            block_index_reg <= res.block_index;
            status_reg      <= res.status;
            last_reg        <= res.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_block_index = block_index_reg;
    assign m_status      = status_reg;
    assign m_last        = last_reg;

endmodule

// ===== verif/tb.sv =====
// testbench for the circular bitmap block allocator: predictor, stimulus and beat checker
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 80;

    typedef struct packed {
        logic [5:0] block_index;
        logic [1:0] status;
        logic       last;
    } alloc_beat_t;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_BURSTY, RX_SLOW} rx_mode_t;

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [cbba_pkg::CFG_ADDR_W-1:0] paddr         = '0;
    logic [cbba_pkg::CFG_DATA_W-1:0] pwdata        = '0;
    logic [cbba_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            s_valid       = 1'b0;
    logic                            s_ready;
    logic [5:0]                      s_first_block = '0;
    logic [6:0]                      s_file_length = '0;
    logic                            m_valid;
    logic                            m_ready       = 1'b0;
    logic [5:0]                      m_block_index;
    logic [1:0]                      m_status;
    logic                            m_last;

    // predictor state
    logic [cbba_pkg::MAX_BLOCKS-1:0] used_map    = '0;
    logic [6:0]                      disk_blocks = 7'd64;
    alloc_beat_t                     pending_beats[$];

    int       mismatch_count = 0;
    int       burst_left     = 0;
    int       idle_cycles    = 0;
    rx_mode_t rx_mode        = RX_ALWAYS;
    int       mode_left      = 0;
    int       hold_left      = 0;

    circular_bitmap_block_allocator uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_first_block (s_first_block),
        .s_file_length (s_file_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_block_index (m_block_index),
        .m_status      (m_status),
        .m_last        (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int eff_block_count();
        int nb;
        nb = disk_blocks;
        if (nb == 0)
            nb = 1;
        if (nb > cbba_pkg::MAX_BLOCKS)
            nb = cbba_pkg::MAX_BLOCKS;
        return nb;
    endfunction

    // works out the chain of beats one request gives and claims its blocks
    function automatic void predict_allocation(input logic [5:0] start, input logic [6:0] flen);
        int          nb;
        int          want;
        int          got;
        int          pos;
        int          seen;
        alloc_beat_t beat;
        nb   = eff_block_count();
        want = flen;
        if (want == 0)
            want = 1;
        if (want > cbba_pkg::MAX_BLOCKS)
            want = cbba_pkg::MAX_BLOCKS;
        if (start >= nb || used_map[start]) begin
            beat = '{block_index: 6'd0, status: cbba_pkg::STAT_USED, last: 1'b1};
            pending_beats.push_back(beat);
            return;
        end
        used_map[start] = 1'b1;
        beat = '{block_index: start, status: cbba_pkg::STAT_CLAIMED, last: 1'b0};
        pending_beats.push_back(beat);
        got  = 1;
        pos  = start;
        seen = 1;
        while (got < want && seen < nb) begin
            pos++;
            if (pos >= nb)
                pos = 0;
            seen++;
            if (!used_map[pos]) begin
                used_map[pos] = 1'b1;
                beat = '{block_index: 6'(pos), status: cbba_pkg::STAT_CLAIMED, last: 1'b0};
                pending_beats.push_back(beat);
                got++;
            end
        end
        if (got < want) begin
            beat = '{block_index: 6'd0, status: cbba_pkg::STAT_NOSPACE, last: 1'b1};
            pending_beats.push_back(beat);
        end else begin
            pending_beats[pending_beats.size()-1].last = 1'b1;
        end
    endfunction

    function automatic logic [5:0] pick_free_start();
        int nb;
        int free_list[$];
        nb = eff_block_count();
        for (int i = 0; i < nb; i++)
            if (!used_map[i])
                free_list.push_back(i);
        if (free_list.size() == 0)
            return 6'($urandom_range(0, 63));
        return 6'(free_list[$urandom_range(0, free_list.size() - 1)]);
    endfunction

    // one request beat; called and returning in the time step of a rising edge
    task automatic send_request(input logic [5:0] start, input logic [6:0] flen);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 20);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_first_block <= start;
        s_file_length <= flen;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
        predict_allocation(start, flen);
    endtask

    // drop the request channel and let the block drain before touching the register
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_num_blocks(input logic [6:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {cbba_pkg::REG_NUM_BLOCKS, 2'b00};
        pwdata  <= cbba_pkg::CFG_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        disk_blocks = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_basic_claims();
        send_request(6'd0, 7'd0);     // zero length claims one block
        send_request(6'd0, 7'd1);     // start block already used
        send_request(6'd63, 7'd2);    // top block, scan wraps past used block 0
        send_request(6'd2, 7'd3);
    endtask

    task automatic test_small_disk();
        wait_idle();
        write_num_blocks(7'd8);
        send_request(6'd8, 7'd1);     // start just outside the disk
        send_request(6'd63, 7'd1);    // far outside the disk
        send_request(6'd5, 7'd127);   // oversized length, full circle, runs out of space
        send_request(6'd7, 7'd1);
    endtask

    task automatic test_block_count_extremes();
        wait_idle();
        write_num_blocks(7'd0);       // acts as a single block
        send_request(6'd0, 7'd1);
        send_request(6'd1, 7'd5);
        wait_idle();
        write_num_blocks(7'd127);     // saturates to the full disk
        send_request(6'd63, 7'd0);
        send_request(6'd8, 7'd2);
        wait_idle();
        write_num_blocks(7'd4);       // shrunk count, higher bits keep their state
        send_request(6'd3, 7'd1);
        send_request(6'd9, 7'd1);
    endtask

    task automatic run_random_phase(input logic [6:0] nb_value, input int count);
        logic [5:0] start;
        logic [6:0] flen;
        int         pick;
        wait_idle();
        write_num_blocks(nb_value);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                start = pick_free_start();
                if ($urandom_range(0, 9) == 0)
                    flen = 7'($urandom_range(4, 127));
                else
                    flen = 7'($urandom_range(0, 3));
            end else begin
                start = 6'($urandom_range(0, 63));
                flen  = 7'($urandom_range(0, 127));
            end
            send_request(start, flen);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(7'd12, 49);
        run_random_phase(7'd24, 49);
        run_random_phase(7'd1, 49);
        run_random_phase(7'd40, 49);
        run_random_phase(7'd127, 49);
        run_random_phase(7'd64, 49);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_claims();
        test_small_disk();
        test_block_count_extremes();
        test_random_traffic();
        s_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("circular_bitmap_block_allocator verification clean");
        else
            $display("circular_bitmap_block_allocator verification failed");
        $finish;
    end

    // receiver back-pressure, switching between patterns
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            mode_left <= $urandom_range(50, 300);
            rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS: m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_BURSTY: begin
                if (hold_left > 0) begin
                    hold_left <= hold_left - 1;
                end else begin
                    m_ready   <= !m_ready;
                    hold_left <= $urandom_range(0, 30);
                end
            end
            default:   m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        alloc_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                $display("%0t: expected no beat, got index %0d status %0d last %0d",
                         $realtime, m_block_index, m_status, m_last);
                mismatch_count++;
            end else begin
                want = pending_beats.pop_front();
                if (m_block_index !== want.block_index) begin
                    $display("%0t: block_index expected %0d got %0d",
                             $realtime, want.block_index, m_block_index);
                    mismatch_count++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $realtime, want.status, m_status);
                    mismatch_count++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last expected %0d got %0d",
                             $realtime, want.last, m_last);
                    mismatch_count++;
                end
            end
        end
    end

    // no beat on either channel for too long means the block has hung
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("circular_bitmap_block_allocator verification failed");
            $finish;
        end
    end

endmodule

// ===== files.f =====
hw/rtl/cbba_pkg.sv
hw/rtl/cbba_ram.sv
hw/rtl/cbba_seq.sv
hw/rtl/circular_bitmap_block_allocator.sv
verif/tb.sv
